// ===== hw/rtl/sds_pkg.sv =====
`default_nettype none

package sds_pkg;

  // Fixed field widths and the queue depth
  localparam int SAMPLE_W = 24;
  localparam int COUNT_W  = 21;
  localparam int INDEX_W  = 20;
  localparam int MAG_W    = 24;
  localparam int SQ_W     = 2 * MAG_W;
  localparam int SUM_W    = 64;
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_a;
    logic signed [SAMPLE_W-1:0] sample_b;
    logic                       has_a;
    logic                       has_b;
    logic                       last_frame;
  } sds_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0]  frames_compared;
    logic [COUNT_W-1:0]  differing_frames;
    logic [MAG_W-1:0]    max_abs_diff;
    logic [INDEX_W-1:0]  worst_frame;
    logic                worst_valid;
    logic [MAG_W-1:0]    rms_diff;
  } sds_out_t;

  // Frame class decided by the front end
  typedef enum logic [1:0] {
    KIND_NONE,
    KIND_LONE,
    KIND_SAME,
    KIND_DIFF
  } sds_kind_t;

  typedef struct packed {
    sds_kind_t        kind;
    logic [MAG_W-1:0] mag;
    logic             last;
  } sds_entry_t;

  typedef enum logic [1:0] {
    FIN_IDLE,
    FIN_DIV,
    FIN_SQRT,
    FIN_DONE
  } sds_fin_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/stream_difference_statistics_unit.sv =====
// Channel  Direction  Handshake            Payload
// frame    in         frame_valid/stall    sds_in_t: two samples, presence flags, last mark
// stats    out        stats_valid/stall    sds_out_t: counts, max delta, worst frame, rms
//
// A frame beat is taken whenever the queue has room; the front end classifies it into a
// four-entry queue and the back end accumulates one frame per cycle through a square
// stage, unless a last frame is held waiting for the finisher. A last frame starts the
// finisher: a restoring divide of the 64-bit sum by the compared count, then a
// digit-by-digit square root; when nothing was compared both are skipped.
// Frames keep flowing while the finisher runs; a second last frame waits at the
// end of the back pipe until the result register is taken, which fills the queue
// and raises frame_stall. Reset (rst, synchronous) clears statistics and control.
`default_nettype none

module stream_difference_statistics_unit import sds_pkg::*; #(
  parameter int FRAME_INDEX_BITS = 20,
  parameter int SAMPLE_BITS      = 24
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    frame_valid,
  output logic         frame_stall,
  input  wire sds_in_t frame,
  output logic         stats_valid,
  input  wire logic    stats_stall,
  output sds_out_t     stats
);

  logic                      q_push;
  logic                      q_pop;
  logic                      q_full;
  logic                      q_empty;
  sds_entry_t                q_in;
  sds_entry_t                q_out;
  logic                      fin_busy;
  logic                      fin_start;
  sds_out_t                  fin_stats;
  logic [FRAME_INDEX_BITS:0] fin_count;
  logic [SUM_W-1:0]          fin_sum;

  sds_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .frame_valid(frame_valid),
    .frame_stall(frame_stall),
    .frame      (frame),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_in)
  );

  sds_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_data(q_in),
    .pop      (q_pop),
    .pop_data (q_out),
    .full     (q_full),
    .empty    (q_empty)
  );

  sds_back #(
    .FRAME_INDEX_BITS(FRAME_INDEX_BITS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_data   (q_out),
    .q_empty  (q_empty),
    .q_pop    (q_pop),
    .fin_busy (fin_busy),
    .fin_start(fin_start),
    .fin_stats(fin_stats),
    .fin_count(fin_count),
    .fin_sum  (fin_sum)
  );

  sds_finish #(
    .FRAME_INDEX_BITS(FRAME_INDEX_BITS),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_finish (
    .clk        (clk),
    .rst        (rst),
    .start      (fin_start),
    .stats_in   (fin_stats),
    .count      (fin_count),
    .sum        (fin_sum),
    .busy       (fin_busy),
    .stats_valid(stats_valid),
    .stats_stall(stats_stall),
    .stats      (stats)
  );

`ifndef SYNTH
  a_start_when_free: assert property (@(posedge clk) disable iff (rst)
    fin_start |-> !fin_busy) else $error("finisher started while busy");

  a_start_takes: assert property (@(posedge clk) disable iff (rst)
    fin_start |=> fin_busy) else $error("finisher did not take a last frame");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty) else $error("queue popped while empty");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !stats_valid && !fin_busy) else $error("result pending after reset");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/sds_front.sv =====
`default_nettype none

module sds_front import sds_pkg::*; #(
  parameter int SAMPLE_BITS = 24
) (
  input  wire logic    frame_valid,
  output logic         frame_stall,
  input  wire sds_in_t frame,
  input  wire logic    q_full,
  output logic         q_push,
  output sds_entry_t   q_entry
);

  logic signed [SAMPLE_BITS-1:0] a_low;
  logic signed [SAMPLE_BITS-1:0] b_low;
  logic signed [SAMPLE_BITS:0]   delta;
  logic        [SAMPLE_BITS:0]   abs_delta;

  // Take the beat whenever the queue has room
  assign frame_stall = q_full;
  assign q_push      = frame_valid && !q_full;

  // Difference of the low sample bits, sign extended
  assign a_low     = frame.sample_a[SAMPLE_BITS-1:0];
  assign b_low     = frame.sample_b[SAMPLE_BITS-1:0];
  assign delta     = (SAMPLE_BITS+1)'(a_low) - (SAMPLE_BITS+1)'(b_low);
  assign abs_delta = delta[SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-delta) : (SAMPLE_BITS+1)'(delta);

  // Classify the frame
  always_comb begin
    q_entry.mag  = MAG_W'(abs_delta[SAMPLE_BITS-1:0]);
    q_entry.last = frame.last_frame;
    if (frame.has_a && frame.has_b) begin
      q_entry.kind = (delta != '0) ? KIND_DIFF : KIND_SAME;
    end else if (frame.has_a || frame.has_b) begin
      q_entry.kind = KIND_LONE;
    end else begin
      q_entry.kind = KIND_NONE;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sds_queue.sv =====
`default_nettype none

module sds_queue import sds_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire sds_entry_t push_data,
  input  wire logic       pop,
  output sds_entry_t      pop_data,
  output logic            full,
  output logic            empty
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  sds_entry_t       slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  assign full     = (fill == CNT_W'(QUEUE_DEPTH));
  assign empty    = (fill == '0);
  assign pop_data = slots[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= PTR_W'((CNT_W+1)'(wr_ptr) + 1'b1 == (CNT_W+1)'(QUEUE_DEPTH)
                         ? '0 : wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= PTR_W'((CNT_W+1)'(rd_ptr) + 1'b1 == (CNT_W+1)'(QUEUE_DEPTH)
                         ? '0 : rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sds_back.sv =====
`default_nettype none

module sds_back import sds_pkg::*; #(
  parameter int FRAME_INDEX_BITS = 20
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire sds_entry_t                q_data,
  input  wire logic                      q_empty,
  output logic                           q_pop,
  input  wire logic                      fin_busy,
  output logic                           fin_start,
  output sds_out_t                       fin_stats,
  output logic [FRAME_INDEX_BITS:0]      fin_count,
  output logic [SUM_W-1:0]               fin_sum
);

  localparam int CW = FRAME_INDEX_BITS + 1;

  // Pipeline stages
  logic             s1_valid;
  sds_entry_t       s1;
  logic             s2_valid;
  sds_kind_t        s2_kind;
  logic             s2_last;
  logic [MAG_W-1:0] s2_mag;
  logic [SQ_W-1:0]  s2_sq;
  logic             advance;

  // Statistics
  logic [CW-1:0]               compared_count, compared_count_next;
  logic [CW-1:0]               differ_count, differ_count_next;
  logic [SUM_W-1:0]            square_sum, square_sum_next;
  logic [MAG_W-1:0]            largest_delta, largest_delta_next;
  logic [FRAME_INDEX_BITS-1:0] largest_index, largest_index_next;
  logic                        largest_seen, largest_seen_next;
  logic [FRAME_INDEX_BITS-1:0] index;
  logic [SUM_W:0]              sum_wide;

  // Hold the pipe while a last frame waits for the finisher
  assign advance   = !(s2_valid && s2_last && fin_busy);
  assign q_pop     = advance && !q_empty;
  assign fin_start = advance && s2_valid && s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (advance) begin
      s1_valid <= !q_empty;
      s2_valid <= s1_valid;
    end
  end

  // Square the magnitude between the stages
  always_ff @(posedge clk) begin
    if (advance) begin
      s1      <= q_data;
      s2_kind <= s1.kind;
      s2_last <= s1.last;
      s2_mag  <= s1.mag;
      s2_sq   <= SQ_W'(s1.mag) * SQ_W'(s1.mag);
    end
  end

  assign index    = compared_count[FRAME_INDEX_BITS] ? '1
                                                     : compared_count[FRAME_INDEX_BITS-1:0];
  assign sum_wide = (SUM_W+1)'(square_sum) + (SUM_W+1)'(s2_sq);

  // Accumulate one frame
  always_comb begin
    compared_count_next = compared_count;
    differ_count_next   = differ_count;
    square_sum_next     = square_sum;
    largest_delta_next  = largest_delta;
    largest_index_next  = largest_index;
    largest_seen_next   = largest_seen;
    unique case (s2_kind)
      KIND_DIFF: begin
        if (!differ_count[FRAME_INDEX_BITS]) differ_count_next = differ_count + 1'b1;
        if (!compared_count[FRAME_INDEX_BITS]) compared_count_next = compared_count + 1'b1;
        square_sum_next = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
        if (s2_mag > largest_delta) begin
          largest_delta_next = s2_mag;
          largest_index_next = index;
        end
        largest_seen_next = 1'b1;
      end
      KIND_SAME: begin
        if (!compared_count[FRAME_INDEX_BITS]) compared_count_next = compared_count + 1'b1;
      end
      KIND_LONE: begin
        if (!differ_count[FRAME_INDEX_BITS]) differ_count_next = differ_count + 1'b1;
      end
      KIND_NONE: begin
      end
      default: begin
      end
    endcase
  end

  // Hand the finished statistics over
  always_comb begin
    fin_stats.frames_compared  = COUNT_W'(compared_count_next);
    fin_stats.differing_frames = COUNT_W'(differ_count_next);
    fin_stats.max_abs_diff     = largest_delta_next;
    fin_stats.worst_frame      = INDEX_W'(largest_index_next);
    fin_stats.worst_valid      = largest_seen_next;
    fin_stats.rms_diff         = '0;
    fin_count                  = compared_count_next;
    fin_sum                    = square_sum_next;
  end

  // Update or clear the statistics
  always_ff @(posedge clk) begin
    if (rst || fin_start) begin
      compared_count <= '0;
      differ_count   <= '0;
      square_sum     <= '0;
      largest_delta  <= '0;
      largest_index  <= '0;
      largest_seen   <= 1'b0;
    end else if (advance && s2_valid) begin
      compared_count <= compared_count_next;
      differ_count   <= differ_count_next;
      square_sum     <= square_sum_next;
      largest_delta  <= largest_delta_next;
      largest_index  <= largest_index_next;
      largest_seen   <= largest_seen_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/sds_finish.sv =====
`default_nettype none

module sds_finish import sds_pkg::*; #(
  parameter int FRAME_INDEX_BITS = 20,
  parameter int SAMPLE_BITS      = 24
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire sds_out_t                  stats_in,
  input  wire logic [FRAME_INDEX_BITS:0] count,
  input  wire logic [SUM_W-1:0]          sum,
  output logic                           busy,
  output logic                           stats_valid,
  input  wire logic                      stats_stall,
  output sds_out_t                       stats
);

  localparam int CW         = FRAME_INDEX_BITS + 1;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int SREM_W     = ROOT_W + 2;
  localparam int STEP_W     = $clog2(SUM_W);
  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = SUM_W / 2;
  localparam logic [ROOT_W-1:0] RMS_MAX = ROOT_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  sds_fin_state_t state, state_next;

  sds_out_t          res;
  logic [CW-1:0]     divisor;
  logic [SUM_W-1:0]  work;
  logic [CW-1:0]     div_rem;
  logic [STEP_W-1:0] step;
  logic [SREM_W-1:0] sq_rem;
  logic [ROOT_W-1:0] root;

  logic [CW:0]       div_shift;
  logic              div_ge;
  logic [CW:0]       div_diff;
  logic [SREM_W+1:0] sq_shift;
  logic [SREM_W+1:0] sq_trial;
  logic              sq_ge;

  // One quotient bit per cycle
  assign div_shift = {div_rem, work[SUM_W-1]};
  assign div_ge    = div_shift >= {1'b0, divisor};
  assign div_diff  = div_shift - {1'b0, divisor};

  // One root bit per cycle
  assign sq_shift = {sq_rem, work[SUM_W-1:SUM_W-2]};
  assign sq_trial = {2'b00, root, 2'b01};
  assign sq_ge    = sq_shift >= sq_trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FIN_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    busy        = (state != FIN_IDLE);
    stats_valid = (state == FIN_DONE);
    unique case (state)
      FIN_IDLE: begin
        if (start) state_next = (count == '0) ? FIN_DONE : FIN_DIV;
      end
      FIN_DIV: begin
        if (step == STEP_W'(DIV_STEPS - 1)) state_next = FIN_SQRT;
      end
      FIN_SQRT: begin
        if (step == STEP_W'(SQRT_STEPS - 1)) state_next = FIN_DONE;
      end
      FIN_DONE: begin
        if (!stats_stall) state_next = FIN_IDLE;
      end
      default: state_next = FIN_IDLE;
    endcase
  end

  // Datapath: load, divide, then take the root of the quotient
  always_ff @(posedge clk) begin
    if (state == FIN_IDLE && start) begin
      res     <= stats_in;
      divisor <= count;
      work    <= sum;
      div_rem <= '0;
      step    <= '0;
      sq_rem  <= '0;
      root    <= '0;
    end else if (state == FIN_DIV) begin
      work    <= {work[SUM_W-2:0], div_ge};
      div_rem <= div_ge ? div_diff[CW-1:0] : div_shift[CW-1:0];
      step    <= step + 1'b1;
    end else if (state == FIN_SQRT) begin
      work   <= {work[SUM_W-3:0], 2'b00};
      sq_rem <= sq_ge ? SREM_W'(sq_shift - sq_trial) : SREM_W'(sq_shift);
      root   <= {root[ROOT_W-2:0], sq_ge};
      step   <= step + 1'b1;
    end
  end

  // Present the result with the saturated root
  always_comb begin
    stats          = res;
    stats.rms_diff = MAG_W'((root > RMS_MAX) ? RMS_MAX : root);
  end

endmodule

`default_nettype wire

// ===== tb/stream_difference_statistics_unit_tb.sv =====
module stream_difference_statistics_unit_tb;
  import sds_pkg::*;

  localparam logic [COUNT_W-1:0]  COUNT_CAP = COUNT_W'(1) << INDEX_W;
  localparam logic [INDEX_W-1:0]  INDEX_CAP = '1;
  localparam logic [SAMPLE_W-1:0] S_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [SAMPLE_W-1:0] S_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam int PHASE_ITEMS = 225;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     frame_valid = 1'b0;
  logic     frame_stall;
  sds_in_t  frame_beat = '0;
  logic     stats_valid;
  logic     stats_stall = 1'b0;
  sds_out_t stats_beat;

  sds_in_t  pending_frames[$];
  sds_out_t stats_due[$];
  int       idle_pct = 0;
  int       stall_pct = 0;
  int       mismatch_count = 0;

  // Running statistics of the current frame set
  logic [COUNT_W-1:0] compared_cnt = '0;
  logic [COUNT_W-1:0] differ_cnt = '0;
  logic [SUM_W-1:0]   sq_sum = '0;
  logic [MAG_W-1:0]   top_mag = '0;
  logic [INDEX_W-1:0] top_index = '0;
  logic               top_seen = 1'b0;

  stream_difference_statistics_unit DUT (
    .clk(clk),
    .rst(rst),
    .frame_valid(frame_valid),
    .frame_stall(frame_stall),
    .frame(frame_beat),
    .stats_valid(stats_valid),
    .stats_stall(stats_stall),
    .stats(stats_beat)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("status: fail");
    $finish;
  end

  function automatic logic [COUNT_W-1:0] bump(input logic [COUNT_W-1:0] c);
    return (c < COUNT_CAP) ? c + 1'b1 : COUNT_CAP;
  endfunction

  function automatic logic [31:0] floor_sqrt(input logic [63:0] v);
    logic [31:0] root;
    logic [31:0] trial;
    root = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = root | (32'd1 << i);
      if (64'(trial) * 64'(trial) <= v) root = trial;
    end
    return root;
  endfunction

  // Fold one accepted frame into the statistics; on a last frame queue the result
  task automatic account_frame(input sds_in_t f);
    logic [SAMPLE_W:0]  delta;
    logic [SAMPLE_W:0]  neg;
    logic [MAG_W-1:0]   mag;
    logic [SQ_W-1:0]    sq;
    logic [SUM_W:0]     wide;
    logic [INDEX_W-1:0] idx;
    logic [SUM_W-1:0]   mean;
    logic [31:0]        root;
    sds_out_t           r;
    if (f.has_a && f.has_b) begin
      delta = {f.sample_a[SAMPLE_W-1], f.sample_a} - {f.sample_b[SAMPLE_W-1], f.sample_b};
      neg = -delta;
      mag = delta[SAMPLE_W] ? neg[MAG_W-1:0] : delta[MAG_W-1:0];
      idx = (compared_cnt < COUNT_W'(INDEX_CAP)) ? compared_cnt[INDEX_W-1:0] : INDEX_CAP;
      if (delta != '0) begin
        sq = SQ_W'(mag) * SQ_W'(mag);
        differ_cnt = bump(differ_cnt);
        wide = {1'b0, sq_sum} + (SUM_W+1)'(sq);
        sq_sum = wide[SUM_W] ? '1 : wide[SUM_W-1:0];
        if (mag > top_mag) begin
          top_mag = mag;
          top_index = idx;
        end
        top_seen = 1'b1;
      end
      compared_cnt = bump(compared_cnt);
    end else if (f.has_a || f.has_b) begin
      differ_cnt = bump(differ_cnt);
    end
    if (f.last_frame) begin
      root = '0;
      if (compared_cnt != '0) begin
        mean = sq_sum / SUM_W'(compared_cnt);
        root = floor_sqrt(mean);
      end
      r.frames_compared  = compared_cnt;
      r.differing_frames = differ_cnt;
      r.max_abs_diff     = top_mag;
      r.worst_frame      = top_index;
      r.worst_valid      = top_seen;
      r.rms_diff         = (root > 32'({MAG_W{1'b1}})) ? '1 : root[MAG_W-1:0];
      stats_due.insert(stats_due.size(), r);
      compared_cnt = '0;
      differ_cnt = '0;
      sq_sum = '0;
      top_mag = '0;
      top_index = '0;
      top_seen = 1'b0;
    end
  endtask

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected %0d, got %0d", what, want, got);
  endtask

  task automatic check_stats(input sds_out_t got);
    sds_out_t want;
    if (stats_due.size() == 0) begin
      note_mismatch("stats beat with none due", 0, 1);
    end else begin
      want = stats_due.pop_front();
      if (got.frames_compared != want.frames_compared)
        note_mismatch("frames_compared", want.frames_compared, got.frames_compared);
      if (got.differing_frames != want.differing_frames)
        note_mismatch("differing_frames", want.differing_frames, got.differing_frames);
      if (got.max_abs_diff != want.max_abs_diff)
        note_mismatch("max_abs_diff", want.max_abs_diff, got.max_abs_diff);
      if (got.worst_frame != want.worst_frame)
        note_mismatch("worst_frame", want.worst_frame, got.worst_frame);
      if (got.worst_valid != want.worst_valid)
        note_mismatch("worst_valid", want.worst_valid, got.worst_valid);
      if (got.rms_diff != want.rms_diff)
        note_mismatch("rms_diff", want.rms_diff, got.rms_diff);
    end
  endtask

  // Present the next pending frame once the current beat is taken
  always @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (!frame_valid || !frame_stall) begin
      if (pending_frames.size() > 0 && $urandom_range(99) >= idle_pct) begin
        frame_beat <= pending_frames.pop_front();
        frame_valid <= 1'b1;
      end else begin
        frame_valid <= 1'b0;
      end
    end
  end

  // Stall the stats channel at random
  always @(posedge clk) begin
    if (rst) stats_stall <= 1'b0;
    else stats_stall <= ($urandom_range(99) < stall_pct);
  end

  // Predict on every accepted frame beat
  always @(posedge clk) begin
    if (!rst && frame_valid && !frame_stall) account_frame(frame_beat);
  end

  // Check every accepted stats beat
  always @(posedge clk) begin
    if (!rst && stats_valid && !stats_stall) check_stats(stats_beat);
  end

  function automatic sds_in_t mk(input logic [SAMPLE_W-1:0] a, input logic [SAMPLE_W-1:0] b,
                                 input logic ha, input logic hb, input logic last);
    sds_in_t f;
    f.sample_a = a;
    f.sample_b = b;
    f.has_a = ha;
    f.has_b = hb;
    f.last_frame = last;
    return f;
  endfunction

  task automatic queue_frame(input sds_in_t f);
    while (pending_frames.size() >= 32) @(negedge clk);
    pending_frames.insert(pending_frames.size(), f);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(9))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Generate one frame set with random content, closed by a last frame
  task automatic random_set(input int n_frames, inout int count);
    logic [SAMPLE_W-1:0] a;
    logic [SAMPLE_W-1:0] b;
    int pick;
    for (int k = 0; k < n_frames; k++) begin
      a = pick_sample();
      pick = $urandom_range(9);
      if (pick < 3) b = a;
      else if (pick < 5) b = a + SAMPLE_W'($urandom_range(8)) - SAMPLE_W'(4);
      else b = pick_sample();
      // Both present, then second only, first only, neither
      pick = $urandom_range(99);
      queue_frame(mk(a, b, pick < 78 || (pick >= 88 && pick < 96),
                     pick < 88, k == n_frames - 1));
      count++;
    end
  endtask

  // Hold until every frame is taken and every result has come back
  task automatic drain();
    while (pending_frames.size() != 0 || frame_valid || stats_due.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int count;
    int len;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Empty set: nothing present, last only
    queue_frame(mk(0, 0, 1'b0, 1'b0, 1'b1));
    // Extreme deltas both ways, equal pair, lone frames, absent frame
    queue_frame(mk(S_MAX, S_MIN, 1'b1, 1'b1, 1'b0));
    queue_frame(mk(S_MIN, S_MAX, 1'b1, 1'b1, 1'b0));
    queue_frame(mk(0, 0, 1'b1, 1'b1, 1'b0));
    queue_frame(mk(S_MAX, 0, 1'b1, 1'b0, 1'b0));
    queue_frame(mk(0, S_MIN, 1'b0, 1'b1, 1'b0));
    queue_frame(mk(5, 9, 1'b0, 1'b0, 1'b0));
    queue_frame(mk(SAMPLE_W'(-1), 0, 1'b1, 1'b1, 1'b1));
    // Lone frame ahead of a compared one: index counts compared frames only
    queue_frame(mk(3, 3, 1'b0, 1'b1, 1'b0));
    queue_frame(mk(100, SAMPLE_W'(-100), 1'b1, 1'b1, 1'b1));
    // Nothing differed
    queue_frame(mk(5, 5, 1'b1, 1'b1, 1'b0));
    queue_frame(mk(S_MIN, S_MIN, 1'b1, 1'b1, 1'b0));
    queue_frame(mk(S_MAX, S_MAX, 1'b1, 1'b1, 1'b1));
    // Lone last frame
    queue_frame(mk(7, 8, 1'b1, 1'b0, 1'b1));
    // Tied maxima: the first one wins
    queue_frame(mk(0, 0, 1'b0, 1'b0, 1'b0));
    queue_frame(mk(1, 2, 1'b1, 1'b1, 1'b0));
    queue_frame(mk(2, 0, 1'b1, 1'b1, 1'b0));
    queue_frame(mk(0, 2, 1'b1, 1'b1, 1'b1));
    drain();

    // Random sets under each idling mix
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 46; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 46; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      count = 0;
      while (count < PHASE_ITEMS) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
        random_set(len, count);
      end
      drain();
    end

    // Let any stray result surface
    repeat (200) @(negedge clk);
    if (mismatch_count == 0 && stats_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
